### rtl/core/srp_pkg.sv
// Shared types and constants for the stepper ramp shuttle.
// Holds the payload structs, phase and register codes, and the ramp period table.
// No dependencies.
`default_nettype none

package srp_pkg;

  localparam int PERIOD_BITS = 12;
  localparam int RAMP_FILLED = 550;
  localparam int ROM_AW      = $clog2(RAMP_FILLED);
  localparam int IDX_W       = 11;
  localparam int LOW_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [PERIOD_BITS-1:0] LOW_TIME_PAD = PERIOD_BITS'(14);

  localparam logic [7:0]       WALK_STEPS_RST  = 8'd10;
  localparam logic [IDX_W-1:0] RAMP_LENGTH_RST = IDX_W'(550);
  localparam logic [7:0]       OFF_TIME_RST    = 8'd10;

  typedef enum logic [2:0] {
    PH_ACC    = 3'd0,
    PH_WALK   = 3'd1,
    PH_RUN    = 3'd2,
    PH_DEC    = 3'd3,
    PH_STEADY = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WALK_STEPS  = 2'd0,
    CFG_RAMP_LENGTH = 2'd1,
    CFG_OFF_TIME    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic up_limit;
    logic down_limit;
  } in_item_t;

  typedef struct packed {
    logic             step_pulse;
    logic [7:0]       high_time_us;
    logic [LOW_W-1:0] low_time_us;
    logic             direction;
    logic             motor_enable;
    logic             reverse_pause;
    logic [2:0]       phase;
  } out_item_t;

  localparam logic [PERIOD_BITS-1:0] RAMP_ROM [RAMP_FILLED] = '{
    12'd2610,12'd2620,12'd2620,12'd2620,12'd2620,12'd2620,12'd2619,12'd2619,12'd2618,12'd2618,
    12'd2617,12'd2617,12'd2616,12'd2616,12'd2615,
    12'd2614,12'd2613,12'd2612,12'd2611,12'd2610,12'd2609,12'd2608,12'd2607,12'd2606,12'd2605,
    12'd2604,12'd2602,12'd2601,12'd2600,12'd2598,12'd2597,12'd2595,12'd2594,12'd2592,12'd2590,
    12'd2589,12'd2587,12'd2585,
    12'd2583,12'd2581,12'd2579,12'd2577,12'd2575,12'd2573,12'd2571,12'd2569,12'd2567,12'd2565,
    12'd2562,12'd2560,12'd2558,12'd2555,12'd2553,12'd2550,12'd2548,12'd2545,12'd2543,12'd2540,
    12'd2537,12'd2534,12'd2532,
    12'd2529,12'd2526,12'd2523,12'd2520,12'd2517,12'd2514,12'd2511,12'd2508,12'd2505,12'd2502,
    12'd2498,12'd2495,12'd2492,12'd2489,12'd2485,12'd2482,12'd2478,12'd2475,12'd2471,12'd2468,
    12'd2464,12'd2461,12'd2457,
    12'd2453,12'd2450,12'd2446,12'd2442,12'd2438,12'd2434,12'd2431,12'd2427,12'd2423,12'd2419,
    12'd2415,12'd2411,12'd2406,12'd2402,12'd2398,12'd2394,12'd2390,12'd2385,12'd2381,12'd2377,
    12'd2372,12'd2368,12'd2364,
    12'd2359,12'd2355,12'd2350,12'd2346,12'd2341,12'd2336,12'd2332,12'd2327,12'd2322,12'd2318,
    12'd2313,12'd2308,12'd2303,12'd2298,12'd2293,12'd2289,12'd2284,12'd2279,12'd2274,12'd2269,
    12'd2264,12'd2259,12'd2253,
    12'd2248,12'd2243,12'd2238,12'd2233,12'd2227,12'd2222,12'd2217,12'd2212,12'd2206,12'd2201,
    12'd2195,12'd2190,12'd2185,12'd2179,12'd2174,12'd2168,12'd2163,12'd2157,12'd2151,12'd2146,
    12'd2140,12'd2135,12'd2129,
    12'd2123,12'd2117,12'd2112,12'd2106,12'd2100,12'd2094,12'd2088,12'd2083,12'd2077,12'd2071,
    12'd2065,12'd2059,12'd2053,12'd2047,12'd2041,12'd2035,12'd2029,12'd2023,12'd2017,12'd2011,
    12'd2004,12'd1998,12'd1992,
    12'd1986,12'd1980,12'd1974,12'd1967,12'd1961,12'd1955,12'd1949,12'd1942,12'd1936,12'd1930,
    12'd1923,12'd1917,12'd1910,12'd1904,12'd1898,12'd1891,12'd1885,12'd1878,12'd1872,12'd1865,
    12'd1859,12'd1852,12'd1846,
    12'd1839,12'd1833,12'd1826,12'd1819,12'd1813,12'd1806,12'd1800,12'd1793,12'd1786,12'd1780,
    12'd1773,12'd1766,12'd1759,12'd1753,12'd1746,12'd1739,12'd1732,12'd1726,12'd1719,12'd1712,
    12'd1705,12'd1698,12'd1692,
    12'd1685,12'd1678,12'd1671,12'd1664,12'd1657,12'd1651,12'd1644,12'd1637,12'd1630,12'd1623,
    12'd1616,12'd1609,12'd1602,12'd1595,12'd1588,12'd1581,12'd1574,12'd1567,12'd1560,12'd1553,
    12'd1546,12'd1539,12'd1532,
    12'd1525,12'd1518,12'd1511,12'd1504,12'd1497,12'd1490,12'd1483,12'd1476,12'd1469,12'd1462,
    12'd1455,12'd1448,12'd1441,12'd1434,12'd1427,12'd1420,12'd1413,12'd1406,12'd1398,12'd1391,
    12'd1384,12'd1377,12'd1370,
    12'd1363,12'd1356,12'd1349,12'd1342,12'd1335,12'd1328,12'd1320,12'd1313,12'd1306,12'd1299,
    12'd1292,12'd1285,12'd1278,12'd1271,12'd1264,12'd1257,12'd1250,12'd1243,12'd1235,12'd1228,
    12'd1221,12'd1214,12'd1207,
    12'd1200,12'd1193,12'd1186,12'd1179,12'd1172,12'd1165,12'd1158,12'd1151,12'd1144,12'd1137,
    12'd1130,12'd1123,12'd1116,12'd1109,12'd1102,12'd1095,12'd1088,12'd1081,12'd1074,12'd1067,
    12'd1060,12'd1053,12'd1046,
    12'd1039,12'd1032,12'd1025,12'd1018,12'd1011,12'd1004,12'd997,12'd990,12'd984,12'd977,
    12'd970,12'd963,12'd956,12'd949,12'd943,12'd936,12'd929,12'd922,12'd915,12'd909,12'd902,
    12'd895,12'd888,12'd882,12'd875,12'd868,12'd861,
    12'd855,12'd848,12'd841,12'd835,12'd828,12'd822,12'd815,12'd808,12'd802,12'd795,12'd789,
    12'd782,12'd776,12'd769,12'd763,12'd756,12'd750,12'd743,12'd737,12'd731,12'd724,12'd718,
    12'd711,12'd705,12'd699,12'd692,12'd686,12'd680,12'd674,
    12'd667,12'd661,12'd655,12'd649,12'd643,12'd637,12'd630,12'd624,12'd618,12'd612,12'd606,
    12'd600,12'd594,12'd588,12'd582,12'd576,12'd570,12'd564,12'd558,12'd553,12'd547,12'd541,
    12'd535,12'd529,12'd524,12'd518,12'd512,12'd506,12'd501,
    12'd495,12'd490,12'd484,12'd478,12'd473,12'd467,12'd462,12'd456,12'd451,12'd446,12'd440,
    12'd435,12'd429,12'd424,12'd419,12'd414,12'd408,12'd403,12'd398,12'd393,12'd388,12'd382,
    12'd377,12'd372,12'd367,12'd362,12'd357,12'd352,12'd348,
    12'd343,12'd338,12'd333,12'd328,12'd323,12'd319,12'd314,12'd309,12'd305,12'd300,12'd295,
    12'd291,12'd286,12'd282,12'd277,12'd273,12'd269,12'd264,12'd260,12'd256,12'd251,12'd247,
    12'd243,12'd239,12'd235,12'd230,12'd226,12'd222,12'd218,
    12'd214,12'd210,12'd207,12'd203,12'd199,12'd195,12'd191,12'd188,12'd184,12'd180,12'd177,
    12'd173,12'd170,12'd166,12'd163,12'd159,12'd156,12'd152,12'd149,12'd146,12'd143,12'd139,
    12'd136,12'd133,12'd130,12'd127,12'd124,12'd121,12'd118,
    12'd115,12'd112,12'd109,12'd107,12'd104,12'd101,12'd98,12'd96,12'd93,12'd91,12'd88,12'd86,
    12'd83,12'd81,12'd79,12'd76,12'd74,12'd72,12'd70,12'd68,12'd66,12'd64,12'd62,12'd60,12'd58,
    12'd56,12'd54,12'd52,12'd51,12'd49,12'd47,12'd46,12'd44,12'd43,12'd41,12'd40,12'd39,
    12'd37,12'd36,12'd35,12'd34,12'd33,12'd32,12'd31,12'd30,12'd29,12'd28,12'd27,12'd26,12'd25,
    12'd25,12'd24,12'd24,12'd23,12'd23,12'd22,12'd22,12'd21,12'd21,12'd21,12'd21,12'd21,12'd21,
    12'd20
  };

endpackage

`default_nettype wire

### rtl/core/stepper_ramp_profile_shuttle.sv
// Stepper shuttle: walk, ramp up through the period ROM, run, ramp down at a limit, reverse.
// One transaction per cycle sustained while the output is not stalled by out_ready.
// Stage 1 updates the motion state and reads the ROM; stage 2 forms the pulse low time.
// The ROM read is registered at the same edge as the state update, so the period arrives with stage 1.
// rst_n is synchronous, active low: clears state, pipeline valids and loads register defaults.
// Depends on srp_pkg and srp_ramp_rom.
`default_nettype none

module stepper_ramp_profile_shuttle (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire srp_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output srp_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [srp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [srp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import srp_pkg::*;

  localparam logic [ROM_AW-1:0] ROM_LAST = ROM_AW'(RAMP_FILLED - 1);

  // configuration
  logic [7:0]       walk_steps_r;
  logic [IDX_W-1:0] ramp_length_r;
  logic [7:0]       off_time_r;

  // motion state
  logic             heading_up_r, heading_up_nxt;
  logic             running_r, running_nxt;
  logic [IDX_W-1:0] ramp_idx_r, ramp_idx_nxt;
  phase_t           phase_r, phase_nxt;
  logic [ROM_AW-1:0] period_addr_r, period_addr_nxt;
  logic             dir_r, dir_nxt;
  logic             enable_r, enable_nxt;
  logic             pause;

  // stage 1 (result minus low time) and output register
  logic             s1_valid_r;
  logic             s1_pulse_r;
  logic [7:0]       s1_high_r;
  logic             s1_dir_r;
  logic             s1_enable_r;
  logic             s1_pause_r;
  phase_t           s1_phase_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             in_fire;
  logic             s1_adv;
  logic [PERIOD_BITS-1:0] rom_q;

  logic [PERIOD_BITS:0] pad_sum;
  logic [PERIOD_BITS:0] low_diff;
  logic [LOW_W-1:0]     low_time;

  function automatic logic [ROM_AW-1:0] rom_clamp(input logic [IDX_W-1:0] idx);
    logic [ROM_AW-1:0] a;
    if (idx >= IDX_W'(RAMP_FILLED)) begin
      a = ROM_LAST;
    end else begin
      a = idx[ROM_AW-1:0];
    end
    return a;
  endfunction

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_steps_r  <= WALK_STEPS_RST;
      ramp_length_r <= RAMP_LENGTH_RST;
      off_time_r    <= OFF_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WALK_STEPS:  walk_steps_r  <= cfg_wdata[7:0];
        CFG_RAMP_LENGTH: ramp_length_r <= cfg_wdata[IDX_W-1:0];
        CFG_OFF_TIME:    off_time_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // per-tick motion update
  always_comb begin
    logic             lim;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] idx_dec;
    phase_t           ph;

    lim     = heading_up_r ? in_data.up_limit : in_data.down_limit;
    idx_inc = ramp_idx_r + IDX_W'(1);
    idx_dec = ramp_idx_r - IDX_W'(1);

    heading_up_nxt  = heading_up_r ^ lim;
    pause           = lim;
    enable_nxt      = lim ? 1'b1 : enable_r;
    running_nxt     = running_r;
    ramp_idx_nxt    = ramp_idx_r;
    period_addr_nxt = period_addr_r;
    dir_nxt         = dir_r;
    ph              = phase_r;

    if (!lim && !running_r) begin
      dir_nxt = !heading_up_r;
      ph      = PH_WALK;
    end else if (lim && running_r) begin
      if (ph == PH_ACC || ph == PH_RUN) begin
        ph = PH_DEC;
      end else if (ph == PH_WALK) begin
        ph = PH_STEADY;
      end
    end

    phase_nxt = ph;
    unique case (ph)
      PH_WALK: begin
        ramp_idx_nxt = idx_inc;
        if (idx_inc == IDX_W'(1)) begin
          running_nxt     = 1'b1;
          enable_nxt      = 1'b1;
          period_addr_nxt = '0;
        end else if (idx_inc == {3'b000, walk_steps_r}) begin
          ramp_idx_nxt = '0;
          phase_nxt    = PH_ACC;
        end
      end
      PH_ACC: begin
        // ramp end: index + 1 >= length, compared one bit wider
        if ({1'b0, ramp_idx_r} + (IDX_W+1)'(1) >= {1'b0, ramp_length_r}) begin
          phase_nxt = PH_RUN;
        end
        period_addr_nxt = rom_clamp(ramp_idx_r);
        ramp_idx_nxt    = idx_inc;
      end
      PH_RUN: begin
        period_addr_nxt = (ramp_idx_r == '0) ? '0 : rom_clamp(idx_dec);
      end
      PH_DEC: begin
        if (ramp_idx_r == '0) begin
          phase_nxt = PH_STEADY;
        end else begin
          ramp_idx_nxt    = idx_dec;
          period_addr_nxt = rom_clamp(idx_dec);
          if (idx_dec == '0) begin
            phase_nxt = PH_STEADY;
          end
        end
      end
      default: begin
        if (running_r) begin
          running_nxt  = 1'b0;
          ramp_idx_nxt = '0;
          enable_nxt   = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_up_r  <= 1'b1;
      running_r     <= 1'b0;
      ramp_idx_r    <= '0;
      phase_r       <= PH_STEADY;
      period_addr_r <= '0;
      dir_r         <= 1'b0;
      enable_r      <= 1'b0;
    end else if (in_fire) begin
      heading_up_r  <= heading_up_nxt;
      running_r     <= running_nxt;
      ramp_idx_r    <= ramp_idx_nxt;
      phase_r       <= phase_nxt;
      period_addr_r <= period_addr_nxt;
      dir_r         <= dir_nxt;
      enable_r      <= enable_nxt;
    end
  end

  srp_ramp_rom u_rom (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (period_addr_nxt),
    .rd_data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pulse_r  <= running_nxt;
      s1_high_r   <= running_nxt ? off_time_r : 8'd0;
      s1_dir_r    <= dir_nxt;
      s1_enable_r <= enable_nxt;
      s1_pause_r  <= pause;
      s1_phase_r  <= phase_nxt;
    end
  end

  // low time = period + pad - high, zero without a pulse, floored at zero and capped at the field maximum
  always_comb begin
    pad_sum  = {1'b0, rom_q} + {1'b0, LOW_TIME_PAD};
    low_diff = pad_sum - (PERIOD_BITS+1)'(s1_high_r);
    if (!s1_pulse_r || pad_sum <= (PERIOD_BITS+1)'(s1_high_r)) begin
      low_time = '0;
    end else if (low_diff > (PERIOD_BITS+1)'({LOW_W{1'b1}})) begin
      low_time = '1;
    end else begin
      low_time = low_diff[LOW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r.step_pulse    <= s1_pulse_r;
      out_data_r.high_time_us  <= s1_high_r;
      out_data_r.low_time_us   <= low_time;
      out_data_r.direction     <= s1_dir_r;
      out_data_r.motor_enable  <= s1_enable_r;
      out_data_r.reverse_pause <= s1_pause_r;
      out_data_r.phase         <= s1_phase_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/srp_ramp_rom.sv
// Ramp period ROM with a registered, enabled read port.
// Depends on srp_pkg for the table contents and widths.
`default_nettype none

module srp_ramp_rom (
  input  wire logic                              clk,
  input  wire logic                              rd_en,
  input  wire logic [srp_pkg::ROM_AW-1:0]        rd_addr,
  output logic      [srp_pkg::PERIOD_BITS-1:0]   rd_data
);
  import srp_pkg::*;

  logic [PERIOD_BITS-1:0] rd_data_r;

  // addresses past the filled part never arrive; upstream clamps them
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= RAMP_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/srp_checker.sv
// Port-level checks for stepper_ramp_profile_shuttle, attached by bind.
// Depends on srp_pkg for the payload types.
`default_nettype none

module srp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire srp_pkg::out_item_t out_data
);
  import srp_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // two-stage pipe: an accepted transaction is followed by a valid result at the output
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.step_pulse |->
      out_data.high_time_us == 8'd0 && out_data.low_time_us == '0)
    else $error("pulse timing set without a pulse");

  a_pulse_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_pulse |-> out_data.motor_enable)
    else $error("pulse issued with driver disabled");

endmodule

bind stepper_ramp_profile_shuttle srp_checker u_srp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### test/tb_stepper_ramp_profile_shuttle.sv
// Testbench for stepper_ramp_profile_shuttle: a directed table, then randomized motion runs.
// A local motion predictor checks every result; uses srp_pkg types, codes and period table.
// Needs only the RTL (srp_pkg, srp_ramp_rom and the top level).
module tb_stepper_ramp_profile_shuttle;
  timeunit 1ns;
  timeprecision 1ps;

  import srp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  stepper_ramp_profile_shuttle dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Directed table row: either a register write or one transaction, optionally with a
  // hand-typed expected result.
  typedef struct {
    bit         is_cfg;
    cfg_reg_t   reg_sel;
    logic [10:0] cfg_val;
    in_item_t   stim;
    bit         typed;
    out_item_t  want;
  } script_row_t;

  typedef struct {
    int walk;
    int ramp;
    int pulse_hi;
    int send_pct;
    int stall_pct;
    int n_items;
    int span;
    int noise;
  } run_plan_t;

  // Predictor state and register mirror
  logic        going_up;
  logic        moving;
  logic [10:0] ramp_pos;
  phase_t      cur_phase;
  logic [11:0] period_now;
  logic        drive_dir;
  logic        drive_en;
  logic [7:0]  walk_cfg;
  logic [10:0] ramp_len_cfg;
  logic [7:0]  pulse_hi_cfg;

  out_item_t   expected_q[$];
  script_row_t script[$];
  run_plan_t   plans[8];

  int mismatches = 0;
  int cycles = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("stepper_ramp_profile_shuttle test failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus long holds requested by the stimulus
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic [11:0] ramp_period(logic [10:0] pos);
    if (pos >= RAMP_FILLED) return RAMP_ROM[RAMP_FILLED-1];
    return RAMP_ROM[pos];
  endfunction

  // One step-loop tick of the shuttle; updates the predictor state.
  function automatic out_item_t step_shuttle(in_item_t it);
    logic        hit;
    logic        dir_now;
    logic [12:0] tot;
    logic [12:0] low;
    out_item_t   r;
    hit = going_up ? it.up_limit : it.down_limit;
    dir_now = ~going_up;
    if (hit) begin
      going_up = ~going_up;
      drive_en = 1'b1;
    end
    if (!hit && !moving) begin
      drive_dir = dir_now;
      cur_phase = PH_WALK;
    end else if (hit && moving) begin
      if (cur_phase == PH_ACC || cur_phase == PH_RUN) cur_phase = PH_DEC;
      else if (cur_phase == PH_WALK) cur_phase = PH_STEADY;
    end
    case (cur_phase)
      PH_WALK: begin
        ramp_pos = ramp_pos + 11'd1;
        if (ramp_pos == 11'd1) begin
          moving = 1'b1;
          drive_en = 1'b1;
          period_now = ramp_period(11'd0);
        end else if (ramp_pos == {3'b000, walk_cfg}) begin
          ramp_pos = '0;
          cur_phase = PH_ACC;
        end
      end
      PH_ACC: begin
        if ({1'b0, ramp_pos} + 12'd1 >= {1'b0, ramp_len_cfg}) cur_phase = PH_RUN;
        period_now = ramp_period(ramp_pos);
        ramp_pos = ramp_pos + 11'd1;
      end
      PH_RUN: begin
        period_now = ramp_period((ramp_pos == 0) ? 11'd0 : ramp_pos - 11'd1);
      end
      PH_DEC: begin
        // count zero drops straight to steady, period kept
        if (ramp_pos == 0) begin
          cur_phase = PH_STEADY;
        end else begin
          ramp_pos = ramp_pos - 11'd1;
          if (ramp_pos == 0) cur_phase = PH_STEADY;
          period_now = ramp_period(ramp_pos);
        end
      end
      default: begin
        if (moving) begin
          moving = 1'b0;
          period_now = '0;
          ramp_pos = '0;
          drive_en = 1'b0;
        end
      end
    endcase
    r = '0;
    if (moving) begin
      tot = {1'b0, period_now} + 13'd14;
      low = (tot > {5'd0, pulse_hi_cfg}) ? tot - {5'd0, pulse_hi_cfg} : 13'd0;
      if (low > 13'd4095) low = 13'd4095;
      r.step_pulse = 1'b1;
      r.high_time_us = pulse_hi_cfg;
      r.low_time_us = low[11:0];
    end
    r.direction = drive_dir;
    r.motor_enable = drive_en;
    r.reverse_pause = hit;
    r.phase = cur_phase;
    return r;
  endfunction

  task automatic flag_error(string what, out_item_t want, out_item_t got);
    if (mismatches < MAX_REPORTS)
      $display("%s: expected pulse %0d hi %0d lo %0d dir %0d en %0d pause %0d ph %0d, got pulse %0d hi %0d lo %0d dir %0d en %0d pause %0d ph %0d",
               what, want.step_pulse, want.high_time_us, want.low_time_us, want.direction,
               want.motor_enable, want.reverse_pause, want.phase, got.step_pulse,
               got.high_time_us, got.low_time_us, got.direction, got.motor_enable,
               got.reverse_pause, got.phase);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        flag_error("unexpected result transaction", '0, out_data);
      end else begin
        want = expected_q.pop_front();
        if (out_data.step_pulse !== want.step_pulse ||
            out_data.high_time_us !== want.high_time_us ||
            out_data.low_time_us !== want.low_time_us ||
            out_data.direction !== want.direction ||
            out_data.motor_enable !== want.motor_enable ||
            out_data.reverse_pause !== want.reverse_pause ||
            out_data.phase !== want.phase)
          flag_error("result mismatch", want, out_data);
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_pct && gap < 50) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(step_shuttle(it));
  endtask

  // Drop valid, wait out all pending results, then let the pipeline settle.
  task automatic quiet_until_drained(int extra);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [10:0] val);
    quiet_until_drained(4);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      CFG_WALK_STEPS:  walk_cfg = val[7:0];
      CFG_RAMP_LENGTH: ramp_len_cfg = val;
      CFG_OFF_TIME:    pulse_hi_cfg = val[7:0];
      default: ;
    endcase
  endtask

  function automatic script_row_t item_row(logic up, logic dn);
    script_row_t r;
    r = '{1'b0, CFG_WALK_STEPS, 11'd0, in_item_t'({up, dn}), 1'b0, '0};
    return r;
  endfunction

  function automatic script_row_t typed_row(logic up, logic dn, out_item_t w);
    script_row_t r;
    r = item_row(up, dn);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic script_row_t cfg_row(cfg_reg_t sel, int val);
    script_row_t r;
    r = '{1'b1, sel, val[10:0], in_item_t'(2'b00), 1'b0, '0};
    return r;
  endfunction

  initial begin : stimulus
    in_item_t it;
    int trip_left;
    going_up = 1'b1;
    moving = 1'b0;
    ramp_pos = '0;
    cur_phase = PH_STEADY;
    period_now = '0;
    drive_dir = 1'b0;
    drive_en = 1'b0;
    walk_cfg = WALK_STEPS_RST;
    ramp_len_cfg = RAMP_LENGTH_RST;
    pulse_hi_cfg = OFF_TIME_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limit while idle (both switches), then first walk step heading down
    script.push_back(typed_row(1, 1, out_item_t'{1'b0, 8'd0, 12'd0, 1'b0, 1'b1, 1'b1, PH_STEADY}));
    script.push_back(typed_row(0, 0, out_item_t'{1'b1, 8'd10, 12'd2614, 1'b1, 1'b1, 1'b0, PH_WALK}));
    script.push_back(cfg_row(CFG_OFF_TIME, 255));
    script.push_back(typed_row(0, 0, out_item_t'{1'b1, 8'd255, 12'd2369, 1'b1, 1'b1, 1'b0, PH_WALK}));
    script.push_back(cfg_row(CFG_WALK_STEPS, 3));
    script.push_back(cfg_row(CFG_RAMP_LENGTH, 4));
    script.push_back(cfg_row(CFG_OFF_TIME, 0));
    script.push_back(typed_row(0, 0, out_item_t'{1'b1, 8'd0, 12'd2624, 1'b1, 1'b1, 1'b0, PH_ACC}));
    // short ramp into run, opposite switch ignored, reversal and ramp down
    repeat (5) script.push_back(item_row(0, 0));
    script.push_back(item_row(1, 0));
    script.push_back(item_row(0, 1));
    repeat (4) script.push_back(item_row(0, 0));
    // limit during walk goes to steady
    repeat (2) script.push_back(item_row(0, 0));
    script.push_back(item_row(1, 0));
    script.push_back(item_row(0, 0));
    // reversal right at the start of acceleration: decelerate from count zero
    repeat (3) script.push_back(item_row(0, 0));
    script.push_back(item_row(0, 1));

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_reg(script[i].reg_sel, script[i].cfg_val);
      end else begin
        send_item(script[i].stim);
        if (script[i].typed) expected_q[expected_q.size()-1] = script[i].want;
      end
    end

    //           walk ramp  hi  send stall items span noise
    plans[0] = '{3,   8,    0,   0,  0,  100,  30,  10};
    plans[1] = '{0,   5,    255, 50, 0,  80,   40,  15};
    plans[2] = '{1,   0,    128, 0,  50, 80,   40,  15};
    plans[3] = '{255, 1,    10,  37, 37, 120,  400, 5};
    plans[4] = '{2,   600,  255, 0,  0,  620,  720, 0};
    plans[5] = '{7,   2047, 1,   37, 37, 100,  60,  20};
    plans[6] = '{4,   2,    200, 50, 0,  80,   50,  10};
    plans[7] = '{10,  550,  10,  0,  50, 80,   80,  10};

    foreach (plans[p]) begin
      write_reg(CFG_WALK_STEPS, plans[p].walk[10:0]);
      write_reg(CFG_RAMP_LENGTH, plans[p].ramp[10:0]);
      write_reg(CFG_OFF_TIME, plans[p].pulse_hi[10:0]);
      send_pct = plans[p].send_pct;
      stall_pct = plans[p].stall_pct;
      trip_left = $urandom_range(plans[p].span * 3 / 4, plans[p].span);
      for (int k = 0; k < plans[p].n_items; k++) begin
        if (p == 0 && k == 40) holds_asked++;
        if (p == 1 && k == 40) quiet_until_drained(0);
        if ($urandom_range(0, 99) < plans[p].noise) begin
          it = in_item_t'($urandom_range(0, 3));
        end else if (trip_left == 0) begin
          // switch in the travel direction
          it.up_limit = going_up;
          it.down_limit = ~going_up;
          trip_left = $urandom_range(plans[p].span * 3 / 4, plans[p].span);
        end else begin
          it = '0;
          trip_left--;
        end
        send_item(it);
      end
    end

    quiet_until_drained(8);
    if (expected_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("stepper_ramp_profile_shuttle test passed");
    end else begin
      $display("stepper_ramp_profile_shuttle test failed");
    end
    $finish;
  end

endmodule

### stepper_ramp_profile_shuttle.f
rtl/core/srp_pkg.sv
rtl/core/srp_ramp_rom.sv
rtl/core/stepper_ramp_profile_shuttle.sv
rtl/core/srp_checker.sv
test/tb_stepper_ramp_profile_shuttle.sv
